/* rtl/core/tsd_pkg.sv */
package tsd_pkg;

  typedef logic [5:0][7:0] magic_t;
  typedef logic [8:0] offset_t;
  typedef logic [32:0] size_t;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_MAGIC = 2'd1;
  localparam logic [1:0] ERR_TYPE  = 2'd2;

  localparam logic [1:0] MC_EMPTY = 2'd0;
  localparam logic [1:0] MC_USTAR = 2'd1;
  localparam logic [1:0] MC_OTHER = 2'd2;

  localparam offset_t SIZE_OFF   = 9'd124;
  localparam offset_t SIZE_END   = 9'd135;
  localparam offset_t TYPE_OFF   = 9'd156;
  localparam offset_t MAGIC_OFF  = 9'd257;
  localparam offset_t MAGIC_END  = 9'd263;
  localparam offset_t PREFIX_OFF = 9'd345;
  localparam offset_t LAST_OFF   = 9'd511;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_FIVE = 8'h35;

  localparam logic [4:0][7:0] USTAR = {8'h72, 8'h61, 8'h74, 8'h73, 8'h75};

endpackage

/* rtl/core/tsd_magic_check.sv */
module tsd_magic_check
  import tsd_pkg::*;
(
  input  magic_t     magic,
  output logic [1:0] mclass
);

  logic [5:0] in_len;
  logic [5:0] solid;
  logic [2:0] first;
  logic [2:0] last;
  logic       seen_zero;
  logic       any_solid;

  always_comb begin
    seen_zero = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (magic[i] == 8'h00) seen_zero = 1'b1;
      in_len[i] = !seen_zero;
      solid[i] = in_len[i] && !(magic[i] == 8'h20 ||
                 (magic[i] >= 8'h09 && magic[i] <= 8'h0d));
    end
  end

  always_comb begin
    first = 3'd0;
    last = 3'd0;
    for (int i = 5; i >= 0; i--) begin
      if (solid[i]) first = 3'(i);
    end
    for (int i = 0; i < 6; i++) begin
      if (solid[i]) last = 3'(i);
    end
  end

  assign any_solid = |solid;

  always_comb begin
    priority if (!any_solid) begin
      mclass = MC_EMPTY;
    end else if (first == 3'd0 && last == 3'd4 && magic[4:0] == USTAR) begin
      mclass = MC_USTAR;
    end else if (first == 3'd1 && last == 3'd5 && magic[5:1] == USTAR) begin
      mclass = MC_USTAR;
    end else begin
      mclass = MC_OTHER;
    end
  end

endmodule

/* rtl/core/tar_stream_deframer_core.sv */
// tar archive deframer, one archive byte per input beat
// input channel: in_valid / in_ready carry in_byte, the raw archive stream
// output channel: out_valid / out_ready carry one result per beat:
//   kind header with is_directory and entry_size, kind data with data_byte
//   and last_data, kind end of archive, or kind error with error_code
// a byte is taken into an input register, decoded by one level of logic
// and its result lands in an output register; one byte is accepted
// every cycle unless in_ready drops on a receiver stall
// the header result appears on the last byte of each 512-byte header block
// directory content, block padding and header bytes give no result
// when the receiver stalls, the output register holds its beat and the
// input register fills; in_ready drops only while both are full
// after an end or error result every further byte is consumed silently
// reset (rst, synchronous) empties both registers and returns the parser
// to the start of a header block; no clearing pass is needed
module tar_stream_deframer_core
  import tsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic        is_directory,
  output logic [32:0] entry_size,
  output logic [7:0]  data_byte,
  output logic        last_data,
  output logic [1:0]  error_code
);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_CONTENT = 3'd1;
  localparam logic [2:0] PH_PAD     = 3'd2;
  localparam logic [2:0] PH_DONE    = 3'd3;
  localparam logic [2:0] PH_HALT    = 3'd4;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       adv;
  logic       step;

  logic [2:0] phase, phase_next;
  offset_t    block_offset, block_offset_next;
  size_t      size_accum, size_accum_next;
  size_t      bytes_remaining, bytes_remaining_next;
  logic [7:0] type_byte, type_byte_next;
  magic_t     magic_bytes, magic_bytes_next;
  logic       name_empty, name_empty_next;
  logic       prefix_empty, prefix_empty_next;
  logic       entry_is_dir, entry_is_dir_next;

  logic [1:0] mclass;
  logic       res_valid;
  logic [1:0] res_kind;
  logic       res_dir;
  size_t      res_size;
  logic [7:0] res_byte;
  logic       res_last;
  logic [1:0] res_err;
  offset_t    off_inc;
  logic       fname_empty;
  logic       is_last;

  tsd_magic_check u_magic (
    .magic  (magic_bytes),
    .mclass (mclass)
  );

  assign adv      = !out_valid || out_ready;
  assign in_ready = !s1_valid || adv;
  assign step     = s1_valid && adv;
  assign off_inc  = block_offset + 9'd1;
  assign fname_empty = name_empty && !(mclass == MC_USTAR && !prefix_empty);
  assign is_last  = bytes_remaining <= 33'd1;

  always_comb begin
    phase_next           = phase;
    block_offset_next    = block_offset;
    size_accum_next      = size_accum;
    bytes_remaining_next = bytes_remaining;
    type_byte_next       = type_byte;
    magic_bytes_next     = magic_bytes;
    name_empty_next      = name_empty;
    prefix_empty_next    = prefix_empty;
    entry_is_dir_next    = entry_is_dir;
    res_valid = 1'b0;
    res_kind  = KIND_HEADER;
    res_dir   = 1'b0;
    res_size  = '0;
    res_byte  = '0;
    res_last  = 1'b0;
    res_err   = ERR_NONE;
    if (step) begin
      unique case (phase)
        PH_HEADER: begin
          block_offset_next = off_inc;
          if (block_offset == 9'd0) begin
            size_accum_next = '0;
            name_empty_next = (s1_byte == 8'h00);
          end
          if (block_offset >= SIZE_OFF && block_offset < SIZE_END) begin
            size_accum_next = {size_accum[29:0], 3'b000} + {25'd0, s1_byte}
                              - {25'd0, CH_ZERO};
          end
          if (block_offset == TYPE_OFF) type_byte_next = s1_byte;
          if (block_offset >= MAGIC_OFF && block_offset < MAGIC_END) begin
            magic_bytes_next[3'(block_offset - MAGIC_OFF)] = s1_byte;
          end
          if (block_offset == PREFIX_OFF) prefix_empty_next = (s1_byte == 8'h00);
          if (block_offset == LAST_OFF) begin
            res_valid = 1'b1;
            priority if (mclass == MC_OTHER) begin
              phase_next = PH_HALT;
              res_kind   = KIND_ERROR;
              res_err    = ERR_MAGIC;
            end else if (fname_empty) begin
              phase_next = PH_DONE;
              res_kind   = KIND_END;
            end else if (type_byte == 8'h00 || type_byte == CH_ZERO ||
                         type_byte == CH_FIVE) begin
              entry_is_dir_next    = (type_byte == CH_FIVE);
              bytes_remaining_next = size_accum;
              phase_next = (size_accum != 33'd0) ? PH_CONTENT : PH_HEADER;
              res_kind   = KIND_HEADER;
              res_dir    = (type_byte == CH_FIVE);
              res_size   = size_accum;
            end else begin
              phase_next = PH_HALT;
              res_kind   = KIND_ERROR;
              res_err    = ERR_TYPE;
            end
          end
        end
        PH_CONTENT: begin
          block_offset_next = off_inc;
          if (!entry_is_dir) begin
            res_valid = 1'b1;
            res_kind  = KIND_DATA;
            res_byte  = s1_byte;
            res_last  = is_last;
          end
          bytes_remaining_next = is_last ? '0 : bytes_remaining - 33'd1;
          if (is_last) phase_next = (block_offset == LAST_OFF) ? PH_HEADER : PH_PAD;
        end
        PH_PAD: begin
          block_offset_next = off_inc;
          if (block_offset == LAST_OFF) phase_next = PH_HEADER;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
      phase           <= PH_HEADER;
      block_offset    <= '0;
      size_accum      <= '0;
      bytes_remaining <= '0;
      type_byte       <= '0;
      magic_bytes     <= '0;
      name_empty      <= 1'b0;
      prefix_empty    <= 1'b0;
      entry_is_dir    <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (adv) out_valid <= res_valid;
      phase           <= phase_next;
      block_offset    <= block_offset_next;
      size_accum      <= size_accum_next;
      bytes_remaining <= bytes_remaining_next;
      type_byte       <= type_byte_next;
      magic_bytes     <= magic_bytes_next;
      name_empty      <= name_empty_next;
      prefix_empty    <= prefix_empty_next;
      entry_is_dir    <= entry_is_dir_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) s1_byte <= in_byte;
    if (adv && res_valid) begin
      kind         <= res_kind;
      is_directory <= res_dir;
      entry_size   <= res_size;
      data_byte    <= res_byte;
      last_data    <= res_last;
      error_code   <= res_err;
    end
  end

endmodule

/* rtl/core/tsd_checker.sv */
module tsd_checker
  import tsd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic        is_directory,
  input logic [32:0] entry_size,
  input logic [7:0]  data_byte,
  input logic        last_data,
  input logic [1:0]  error_code
);

  logic stopped;

  always_ff @(posedge clk) begin
    if (rst) begin
      stopped <= 1'b0;
    end else if (out_valid && out_ready && (kind == KIND_END || kind == KIND_ERROR)) begin
      stopped <= 1'b1;
    end
  end

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(entry_size)
      && $stable(data_byte) && $stable(last_data) && $stable(error_code))
    else $error("output beat changed while stalled");

  // nothing follows end of archive or an error
  a_quiet_after_stop: assert property (@(posedge clk) disable iff (rst)
    stopped |-> !out_valid)
    else $error("result after end or error");

  a_error_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
    else $error("error code does not match kind");

  a_data_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> data_byte == 8'd0 && !last_data)
    else $error("data fields set on a non-data beat");

  a_header_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_HEADER |-> entry_size == 33'd0 && !is_directory)
    else $error("header fields set on a non-header beat");

endmodule

bind tar_stream_deframer_core tsd_checker u_tsd_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
  import tsd_pkg::*;

  typedef logic [10:0][7:0] digits_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       is_dir;
    size_t      size;
    logic [7:0] data;
    logic       last;
    logic [1:0] err;
  } result_t;

  typedef enum logic [2:0] {ST_HEADER, ST_CONTENT, ST_PAD, ST_DONE, ST_HALT} parse_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic        is_directory;
  logic [32:0] entry_size;
  logic [7:0]  data_byte;
  logic        last_data;
  logic [1:0]  error_code;

  tar_stream_deframer_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .is_directory(is_directory),
    .entry_size(entry_size),
    .data_byte(data_byte),
    .last_data(last_data),
    .error_code(error_code)
  );

  logic [7:0]   archive_bytes[$];
  result_t      pending_results[$];
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  int unsigned  run_limit = 0;
  bit           in_fire = 1'b0;
  bit           out_fire = 1'b0;
  int unsigned  send_gap = 0;
  int unsigned  recv_hold = 0;
  int unsigned  beats_seen = 0;
  bit           send_quiet = 1'b0;
  bit           recv_quiet = 1'b0;

  // parser copy
  parse_state_t pst = ST_HEADER;
  offset_t      boff = '0;
  size_t        size_acc = '0;
  size_t        left_bytes = '0;
  logic [7:0]   type_b = 8'h00;
  magic_t       magic_r = '0;
  bit           name_nul = 1'b0;
  bit           prefix_nul = 1'b0;
  bit           dir_entry = 1'b0;

  function automatic bit blank(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic [1:0] magic_kind(input magic_t m);
    int len, lo, hi;
    len = 0;
    while (len < 6 && m[len] != 8'h00) len++;
    lo = 0;
    hi = len;
    while (lo < hi && blank(m[lo])) lo++;
    while (hi > lo && blank(m[hi - 1])) hi--;
    if (hi == lo) return MC_EMPTY;
    if (hi - lo != 5) return MC_OTHER;
    for (int k = 0; k < 5; k++) begin
      if (m[lo + k] != USTAR[k]) return MC_OTHER;
    end
    return MC_USTAR;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    offset_t    off;
    logic [1:0] mc;
    bit         last;
    r = '0;
    if (pst == ST_DONE || pst == ST_HALT) return 1'b0;
    off = boff;
    boff = off + 9'd1;
    case (pst)
      ST_HEADER: begin
        if (off == 0) begin
          size_acc = '0;
          name_nul = (b == 8'h00);
        end
        if (off >= SIZE_OFF && off < SIZE_END) size_acc = (size_acc << 3) + b - CH_ZERO;
        if (off == TYPE_OFF) type_b = b;
        if (off >= MAGIC_OFF && off < MAGIC_END) magic_r[off - MAGIC_OFF] = b;
        if (off == PREFIX_OFF) prefix_nul = (b == 8'h00);
        if (off != LAST_OFF) return 1'b0;
        mc = magic_kind(magic_r);
        if (mc == MC_OTHER) begin
          pst = ST_HALT;
          r.kind = KIND_ERROR;
          r.err = ERR_MAGIC;
        end else if (name_nul && !(mc == MC_USTAR && !prefix_nul)) begin
          pst = ST_DONE;
          r.kind = KIND_END;
        end else if (type_b == 8'h00 || type_b == CH_ZERO || type_b == CH_FIVE) begin
          dir_entry = (type_b == CH_FIVE);
          left_bytes = size_acc;
          pst = (size_acc != 0) ? ST_CONTENT : ST_HEADER;
          r.kind = KIND_HEADER;
          r.is_dir = dir_entry;
          r.size = size_acc;
        end else begin
          pst = ST_HALT;
          r.kind = KIND_ERROR;
          r.err = ERR_TYPE;
        end
        return 1'b1;
      end
      ST_CONTENT: begin
        last = (left_bytes <= 1);
        left_bytes = last ? '0 : left_bytes - 1;
        if (last) pst = (boff == 0) ? ST_HEADER : ST_PAD;
        if (dir_entry) return 1'b0;
        r.kind = KIND_DATA;
        r.data = b;
        r.last = last;
        return 1'b1;
      end
      default: begin
        if (boff == 0) pst = ST_HEADER;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic digits_t octal(input size_t v);
    digits_t d;
    for (int i = 0; i < 11; i++) d[i] = CH_ZERO + 8'((v >> (3 * (10 - i))) & 33'd7);
    return d;
  endfunction

  function automatic magic_t make_magic(input string s);
    magic_t m;
    for (int k = 0; k < 6; k++) m[k] = (k < s.len()) ? s[k] : 8'h00;
    return m;
  endfunction

  function automatic magic_t good_magic();
    magic_t m;
    case ($urandom_range(0, 6))
      0: m = '0;
      1: m = make_magic("ustar");
      2: m = make_magic("ustar ");
      3: m = make_magic(" ustar");
      4: begin
        m = make_magic("ustar");
        m[5] = $urandom_range(8'h09, 8'h0D);
      end
      5: for (int k = 0; k < 6; k++) m[k] = $urandom_range(0, 1) ? 8'h20 : 8'h0A;
      default: begin
        for (int k = 1; k < 6; k++) m[k] = $urandom;
        m[0] = 8'h00;
      end
    endcase
    return m;
  endfunction

  task automatic push_random(input int unsigned n);
    repeat (n) archive_bytes.push_back($urandom);
  endtask

  task automatic push_header(input logic [7:0] name0, prefix0, typ, input digits_t sz,
                             input magic_t mg);
    logic [7:0] b;
    for (int k = 0; k < 512; k++) begin
      b = $urandom;
      if (k == 0) b = name0;
      else if (k >= SIZE_OFF && k < SIZE_END) b = sz[k - SIZE_OFF];
      else if (k == TYPE_OFF) b = typ;
      else if (k >= MAGIC_OFF && k < MAGIC_END) b = mg[k - MAGIC_OFF];
      else if (k == PREFIX_OFF) b = prefix0;
      archive_bytes.push_back(b);
    end
  endtask

  task automatic compare_field(input string fname, input logic [32:0] want_v, got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d got %0d", $time, fname, want_v, got_v);
      mismatches++;
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // archive build and run control
  initial begin
    magic_t      mg;
    digits_t     dg;
    size_t       big;
    logic [7:0]  typ, prefix0;

    // empty name but prefix set under ustar, non-digit in the size field wraps: 64 - 1
    dg = octal(0);
    dg[8] = CH_ZERO + 8'd1;
    dg[10] = 8'h2F;
    push_header(8'h00, 8'h01, CH_ZERO, dg, make_magic(" ustar"));
    archive_bytes.push_back(8'h00);
    archive_bytes.push_back(8'hFF);
    push_random(510);

    // end or error entry and bytes that must be swallowed, or a large entry cut short
    case ($urandom_range(0, 3))
      0: begin
        mg = good_magic();
        prefix0 = (magic_kind(mg) == MC_USTAR) ? 8'h00 : 8'($urandom);
        push_header(8'h00, prefix0, $urandom, octal({$urandom, 1'b0}), mg);
        push_random(200);
      end
      1: begin
        for (int k = 1; k < 6; k++) mg[k] = $urandom;
        mg[0] = $urandom_range(8'h21, 8'h7E);
        push_header($urandom, $urandom, $urandom, octal($urandom), mg);
        push_random(200);
      end
      2: begin
        do typ = $urandom; while (typ == 8'h00 || typ == CH_ZERO || typ == CH_FIVE);
        push_header($urandom_range(1, 255), $urandom, typ, octal($urandom), good_magic());
        push_random(200);
      end
      default: begin
        big = {1'($urandom), 32'($urandom)} | 33'h1000;
        dg = octal(big);
        if ($urandom_range(0, 1)) begin
          for (int k = 0; k < 11; k++) dg[k] = $urandom;
        end
        push_header($urandom_range(1, 255), $urandom,
                    $urandom_range(0, 1) ? CH_FIVE : CH_ZERO, dg, good_magic());
        push_random($urandom_range(0, 400));
      end
    endcase

    run_limit = (archive_bytes.size() * 24 + 2000) * 4;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (archive_bytes.size() == 0 && !in_valid);
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // byte driver
  always @(negedge clk) begin
    bit nv;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_fire)) begin
      nv = 1'b0;
      if (send_gap != 0) begin
        send_gap--;
      end else if (archive_bytes.size() != 0) begin
        in_byte <= archive_bytes.pop_front();
        nv = 1'b1;
        if ($urandom_range(0, 99) == 0) send_quiet = !send_quiet;
        send_gap = send_quiet ? 0 : $urandom_range(0, 11);
      end
      in_valid <= nv;
    end
  end

  // result receiver, with one long hold to back up the input
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_fire) begin
        beats_seen++;
        if ($urandom_range(0, 99) == 0) recv_quiet = !recv_quiet;
        recv_hold = recv_quiet ? 0 : $urandom_range(0, 11);
        if (beats_seen == 40) recv_hold = 600;
      end
      if (recv_hold != 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want, fresh;
    cycles++;
    if (cycles > run_limit) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      in_fire = !rst && in_valid && in_ready;
      out_fire = !rst && out_valid && out_ready;
      if (out_fire) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected beat, expected none got kind %0d", $time, kind);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("kind", want.kind, kind);
          compare_field("is_directory", want.is_dir, is_directory);
          compare_field("entry_size", want.size, entry_size);
          compare_field("data_byte", want.data, data_byte);
          compare_field("last_data", want.last, last_data);
          compare_field("error_code", want.err, error_code);
        end
      end
      if (in_fire && deframe_byte(in_byte, fresh)) pending_results.push_back(fresh);
    end
  end

endmodule
